FILE: hw/rtl/ip_address_text_parser_defines.svh
// ----------------------------------------------------------------------------
// ip_address_text_parser_defines
// Assertion macros shared by the address parser RTL.
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_TEXT_PARSER_DEFINES_SVH
`define IP_ADDRESS_TEXT_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

`define IPAT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ipat assertion failed");

`define IPAT_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("ipat assertion failed");

`define IPAT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("ipat assertion failed");

`else

`define IPAT_ASSERT(lbl, prop)
`define IPAT_ASSERT_IMPL(lbl, pre, post)
`define IPAT_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

FILE: hw/rtl/ipat_pkg.sv
// ----------------------------------------------------------------------------
// ipat_pkg
// Types, character codes and decode helpers for the address text parser.
// ----------------------------------------------------------------------------
package ipat_pkg;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] OctetMax = 8'd255;

  typedef struct packed {
    logic [7:0] ch;
    logic       mode;
  } ipat_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
  } ipat_out_t;

  typedef struct packed {
    logic [3:0][7:0] oct;
    logic [2:0]      cnt;
    logic            saw;
  } quad_t;

  typedef struct packed {
    logic  ok;
    quad_t q;
  } quad_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_res_t;

  typedef struct packed {
    logic [15:0][7:0] bytes;
    logic [4:0]       widx;
    logic [15:0]      grp;
    logic             saw_hex;
    logic [4:0]       gap_pos;
    logic             gap_pres;
    quad_t            quad;
    logic             q_fail;
    logic             q_tail;
    logic             failed;
    logic             at_start;
    logic             lead;
    logic             family;
  } state_t;

  localparam state_t StateReset = '{at_start: 1'b1, default: '0};

  function automatic hex_res_t hex_digit(logic [7:0] c);
    hex_res_t   r;
    logic [7:0] t;
    r = '0;
    t = '0;
    if (c >= ChZero && c <= ChNine) begin
      t = c - ChZero;
      r.ok = 1'b1;
    end else if (c >= ChLowA && c <= ChLowF) begin
      t = c - ChLowA + 8'd10;
      r.ok = 1'b1;
    end else if (c >= ChUpA && c <= ChUpF) begin
      t = c - ChUpA + 8'd10;
      r.ok = 1'b1;
    end
    r.val = t[3:0];
    return r;
  endfunction

  function automatic quad_res_t quad_feed(quad_t q, logic [7:0] c);
    quad_res_t   r;
    logic [1:0]  idx;
    logic [7:0]  cur;
    logic [7:0]  dig;
    logic [11:0] v;
    r.ok = 1'b0;
    r.q = q;
    idx = q.saw ? (q.cnt[1:0] - 2'd1) : q.cnt[1:0];
    cur = q.saw ? q.oct[idx] : 8'd0;
    dig = c - ChZero;
    v = 12'(cur) * 12'd10 + 12'(dig);
    if (c >= ChZero && c <= ChNine) begin
      if ((q.saw || !q.cnt[2]) && v <= 12'(OctetMax)) begin
        r.ok = 1'b1;
        r.q.oct[idx] = v[7:0];
        if (!q.saw) begin
          r.q.cnt = q.cnt + 3'd1;
          r.q.saw = 1'b1;
        end
      end
    end else if (c == ChDot && q.saw && !q.cnt[2]) begin
      r.ok = 1'b1;
      r.q.saw = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/ipat_parse.sv
// ----------------------------------------------------------------------------
// ipat_parse
// Parser state and per-word step logic; builds the result on the terminator.
// ----------------------------------------------------------------------------
`include "ip_address_text_parser_defines.svh"

module ipat_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_valid_i,
  input  ipat_pkg::ipat_in_t  word_i,
  output logic                res_valid_o,
  output ipat_pkg::ipat_out_t res_o
);

  ipat_pkg::state_t    s_q, s_d;
  ipat_pkg::quad_res_t qf;
  ipat_pkg::hex_res_t  hx;
  logic                fam;
  logic                term;

  logic [15:0][7:0] b, b2;
  logic [4:0]       w, sh, kk, gend;
  logic             ok6, ok4;

  assign fam  = s_q.at_start ? word_i.mode : s_q.family;
  assign term = word_i.ch == ipat_pkg::ChNul;
  assign qf   = ipat_pkg::quad_feed(s_q.quad, word_i.ch);
  assign hx   = ipat_pkg::hex_digit(word_i.ch);

  always_comb begin
    s_d = s_q;
    res_valid_o = 1'b0;
    if (step_valid_i) begin
      if (s_q.at_start) begin
        s_d.family = word_i.mode;
        s_d.at_start = 1'b0;
      end
      if (s_q.at_start && word_i.mode && word_i.ch == ipat_pkg::ChColon) begin
        s_d.lead = 1'b1;
      end else if (term) begin
        s_d = ipat_pkg::StateReset;
        res_valid_o = 1'b1;
      end else if (!s_q.failed) begin
        if (!fam) begin
          if (qf.ok) s_d.quad = qf.q;
          else s_d.failed = 1'b1;
        end else if (s_q.lead && word_i.ch != ipat_pkg::ChColon) begin
          s_d.lead = 1'b0;
          s_d.failed = 1'b1;
        end else begin
          s_d.lead = 1'b0;
          if (s_q.q_tail) begin
            if (qf.ok) s_d.quad = qf.q;
            else s_d.failed = 1'b1;
          end else if (hx.ok) begin
            if (s_q.grp[15:12] != 4'd0) begin
              s_d.failed = 1'b1;
            end else begin
              s_d.grp = {s_q.grp[11:0], hx.val};
              s_d.saw_hex = 1'b1;
              if (!s_q.q_fail) begin
                if (qf.ok) s_d.quad = qf.q;
                else s_d.q_fail = 1'b1;
              end
            end
          end else if (word_i.ch == ipat_pkg::ChColon) begin
            s_d.quad = '0;
            s_d.q_fail = 1'b0;
            if (!s_q.saw_hex) begin
              if (s_q.gap_pres) begin
                s_d.failed = 1'b1;
              end else begin
                s_d.gap_pres = 1'b1;
                s_d.gap_pos = s_q.widx;
              end
            end else if (s_q.widx > 5'd14) begin
              s_d.failed = 1'b1;
            end else begin
              s_d.bytes[s_q.widx[3:0]] = s_q.grp[15:8];
              s_d.bytes[s_q.widx[3:0] + 4'd1] = s_q.grp[7:0];
              s_d.widx = s_q.widx + 5'd2;
              s_d.saw_hex = 1'b0;
              s_d.grp = '0;
            end
          end else if (word_i.ch == ipat_pkg::ChDot && s_q.widx <= 5'd12 &&
                       !s_q.q_fail && qf.ok) begin
            s_d.quad = qf.q;
            s_d.q_tail = 1'b1;
            s_d.saw_hex = 1'b0;
          end else begin
            s_d.failed = 1'b1;
          end
        end
      end
    end
  end

  // finish path: place the last token, then expand the gap
  always_comb begin
    b = s_q.bytes;
    w = s_q.widx;
    ok6 = !s_q.failed && !s_q.lead;
    if (s_q.q_tail) begin
      if (s_q.q_fail || s_q.quad.cnt != 3'd4 || w > 5'd12) begin
        ok6 = 1'b0;
      end else begin
        for (int i = 0; i < 4; i++) begin
          b[w[3:0] + 4'(i)] = s_q.quad.oct[i];
        end
        w = w + 5'd4;
      end
    end else if (s_q.saw_hex) begin
      if (w > 5'd14) begin
        ok6 = 1'b0;
      end else begin
        b[w[3:0]] = s_q.grp[15:8];
        b[w[3:0] + 4'd1] = s_q.grp[7:0];
        w = w + 5'd2;
      end
    end
    b2 = b;
    sh = 5'd16 - w;
    gend = s_q.gap_pos + sh;
    kk = '0;
    if (s_q.gap_pres) begin
      if (w[4] || s_q.gap_pos > w) begin
        ok6 = 1'b0;
      end else begin
        for (int k = 0; k < 16; k++) begin
          kk = 5'(k) - sh;
          if (5'(k) >= gend) b2[k] = b[kk[3:0]];
          else if (5'(k) >= s_q.gap_pos) b2[k] = 8'd0;
        end
        w = 5'd16;
      end
    end
    ok6 = ok6 && w == 5'd16;
    ok4 = !s_q.failed && s_q.quad.cnt == 3'd4;

    res_o = '0;
    if (!fam) begin
      res_o.valid_res = ok4;
      if (ok4) begin
        res_o.addr_lo = {32'd0, s_q.quad.oct[0], s_q.quad.oct[1],
                         s_q.quad.oct[2], s_q.quad.oct[3]};
      end
    end else begin
      res_o.valid_res = ok6;
      if (ok6) begin
        for (int i = 0; i < 8; i++) begin
          res_o.addr_hi[63 - 8 * i -: 8] = b2[i];
          res_o.addr_lo[63 - 8 * i -: 8] = b2[i + 8];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= ipat_pkg::StateReset;
    end else begin
      s_q <= s_d;
    end
  end

  `IPAT_ASSERT_NEXT(a_clear_after_term, step_valid_i && term, s_q.at_start)
  `IPAT_ASSERT_IMPL(a_lead_only_v6, s_q.lead, s_q.family && !s_q.at_start)
  `IPAT_ASSERT(a_widx_even_bound, !s_q.widx[0] && s_q.widx <= 5'd16)

endmodule

FILE: hw/rtl/ip_address_text_parser.sv
// A terminator word passes through the input register and then the result register.
// Throughput: one character word per cycle; the input stalls only when a
// terminator meets a result still held by a stalled output register.
// Reset: asynchronous, active low; clears the parser state and both valids.
// ----------------------------------------------------------------------------
// ip_address_text_parser
// IPv4 / IPv6 address text parser with registered input and result stages.
// ----------------------------------------------------------------------------
`include "ip_address_text_parser_defines.svh"

module ip_address_text_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ipat_pkg::ipat_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ipat_pkg::ipat_out_t out_data_o
);

  ipat_pkg::ipat_in_t  in_q;
  logic                in_vld_q;
  ipat_pkg::ipat_out_t out_q, res;
  logic                out_vld_q;
  logic                res_vld;
  logic                term, blocked, adv;

  assign term       = in_q.ch == ipat_pkg::ChNul;
  assign blocked    = term && out_vld_q && out_stall_i;
  assign adv        = in_vld_q && !blocked;
  assign in_stall_o = in_vld_q && blocked;

  ipat_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (adv),
    .word_i       (in_q),
    .res_valid_o  (res_vld),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_vld) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `IPAT_ASSERT_IMPL(a_stall_on_collision, in_stall_o, out_valid_o && out_stall_i && term)
  `IPAT_ASSERT_IMPL(a_invalid_zero, out_valid_o && !out_data_o.valid_res,
                    out_data_o.addr_hi == '0 && out_data_o.addr_lo == '0)
  `IPAT_ASSERT_NEXT(a_term_gives_result, adv && term, out_valid_o)

endmodule
